/* hdl/tqfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tqfd_pkg: shared types and constants for the timecode quarter-frame decoder
// Holds the command codes, the item and result layouts and the decoder state.
// ----------------------------------------------------------------------------
package tqfd_pkg;

  localparam logic [1:0] CMD_QUARTER = 2'd0;
  localparam logic [1:0] CMD_FULL    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [2:0] PIECE_LAST = 3'd7;

  localparam logic [1:0] GROUP_FRAMES  = 2'd0;
  localparam logic [1:0] GROUP_SECONDS = 2'd1;
  localparam logic [1:0] GROUP_MINUTES = 2'd2;
  localparam logic [1:0] GROUP_HOURS   = 2'd3;

  localparam logic signed [10:0] LOST_MAX = 11'sd1023;
  localparam logic signed [10:0] LOST_MIN = -11'sd1023;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] quarter_byte;
    logic [6:0] full_hour_byte;
    logic [6:0] full_minutes;
    logic [6:0] full_seconds;
    logic [6:0] full_frames;
  } tqfd_item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frames;
    logic [1:0] rate_type;
    logic       from_full_frame;
    logic       first_sync;
  } tqfd_result_t;

  typedef struct packed {
    logic [2:0]         expected_piece;
    logic signed [10:0] lost_count;
    logic               synced_once;
    logic [4:0]         frame_acc;
    logic [5:0]         second_acc;
    logic [5:0]         minute_acc;
    logic [4:0]         hour_acc;
  } tqfd_state_t;

endpackage
`default_nettype wire

/* hdl/tqfd_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tqfd_in_if: input channel of the timecode decoder
// Valid/ready channel that carries one MIDI timecode item.
// ----------------------------------------------------------------------------
interface tqfd_in_if;
  logic                valid;
  logic                ready;
  tqfd_pkg::tqfd_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

/* hdl/tqfd_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tqfd_out_if: result channel of the timecode decoder
// Valid/ready channel that carries one decoded timecode item.
// ----------------------------------------------------------------------------
interface tqfd_out_if;
  logic                  valid;
  logic                  ready;
  tqfd_pkg::tqfd_result_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

/* hdl/tqfd_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tqfd_step: next-state and result logic of the timecode decoder
// Merges one quarter-frame nibble, tracks lost pieces and forms the result.
// ----------------------------------------------------------------------------
module tqfd_step (
  input  tqfd_pkg::tqfd_state_t  state,
  input  tqfd_pkg::tqfd_item_t   item,
  output tqfd_pkg::tqfd_state_t  state_next,
  output logic                   emit,
  output tqfd_pkg::tqfd_result_t result
);
  import tqfd_pkg::*;

  logic [3:0]         nib;
  logic [2:0]         piece;
  logic               high;
  logic signed [3:0]  diff;
  logic signed [11:0] sum;
  logic signed [10:0] lost_sat;
  logic [4:0]         hour_new;
  logic               stamp_ok;

  always_comb begin
    nib   = item.quarter_byte[3:0];
    piece = item.quarter_byte[6:4];
    high  = piece[0];
    diff  = $signed({1'b0, piece}) - $signed({1'b0, state.expected_piece});
    sum   = $signed({state.lost_count[10], state.lost_count})
          + $signed({{8{diff[3]}}, diff});
    if (sum > $signed({LOST_MAX[10], LOST_MAX})) begin
      lost_sat = LOST_MAX;
    end else if (sum < $signed({LOST_MIN[10], LOST_MIN})) begin
      lost_sat = LOST_MIN;
    end else begin
      lost_sat = sum[10:0];
    end
    hour_new = high ? {nib[0], state.hour_acc[3:0]} : {state.hour_acc[4], nib};
    stamp_ok = (lost_sat == '0);

    state_next = state;
    emit       = 1'b0;
    result     = '0;

    case (item.cmd)
      CMD_QUARTER: begin
        state_next.expected_piece = piece + 3'd1;
        state_next.lost_count     = lost_sat;
        case (piece[2:1])
          GROUP_FRAMES: begin
            state_next.frame_acc = high ? {nib[0], state.frame_acc[3:0]}
                                        : {state.frame_acc[4], nib};
          end
          GROUP_SECONDS: begin
            state_next.second_acc = high ? {nib[1:0], state.second_acc[3:0]}
                                         : {state.second_acc[5:4], nib};
          end
          GROUP_MINUTES: begin
            state_next.minute_acc = high ? {nib[1:0], state.minute_acc[3:0]}
                                         : {state.minute_acc[5:4], nib};
          end
          GROUP_HOURS: begin
            state_next.hour_acc = hour_new;
          end
          default: begin
            state_next.hour_acc = hour_new;
          end
        endcase
        if (piece == PIECE_LAST) begin
          state_next.expected_piece = '0;
          state_next.lost_count     = '0;
          if (stamp_ok) begin
            emit                    = 1'b1;
            state_next.synced_once  = 1'b1;
            result.hours            = hour_new;
            result.minutes          = state.minute_acc;
            result.seconds          = state.second_acc;
            result.frames           = state.frame_acc;
            result.rate_type        = nib[2:1];
            result.from_full_frame  = 1'b0;
            result.first_sync       = !state.synced_once;
          end
        end
      end
      CMD_FULL: begin
        state_next.expected_piece = '0;
        state_next.lost_count     = '0;
        emit                      = 1'b1;
        result.hours              = item.full_hour_byte[4:0];
        result.minutes            = item.full_minutes[5:0];
        result.seconds            = item.full_seconds[5:0];
        result.frames             = item.full_frames[4:0];
        result.rate_type          = item.full_hour_byte[6:5];
        result.from_full_frame    = 1'b1;
        result.first_sync         = 1'b0;
      end
      CMD_RESTART: begin
        state_next.expected_piece = '0;
        state_next.lost_count     = '0;
        state_next.synced_once    = 1'b0;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/timecode_quarter_frame_decoder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// timecode_quarter_frame_decoder_core: MIDI timecode quarter-frame decoder
// Builds hours, minutes, seconds and frames from quarter-frame and full-frame
// messages and delivers one item for each completed valid timecode.
//
//   Channel | Role   | Item
//   msg     | sink   | command, quarter-frame byte, full-frame bytes
//   tc      | source | hours, minutes, seconds, frames, rate, flags
//
// One item is taken every cycle while the result channel is not stalled; a
// result passes the input register, the single decode stage and the result
// register. Reset clears the decoder state and both valid flags.
// A stalled result holds the decode stage, and the input register refills as
// soon as the stage moves on.
// ----------------------------------------------------------------------------
module timecode_quarter_frame_decoder_core (
  input  wire          clk,
  input  wire          rst,
  tqfd_in_if.sink      msg,
  tqfd_out_if.source   tc
);
  import tqfd_pkg::*;

  logic         held_valid;
  tqfd_item_t   held_item;
  tqfd_state_t  st;
  tqfd_state_t  st_next;
  logic         emit;
  tqfd_result_t res;
  logic         out_free;
  logic         step_en;

  assign out_free  = !tc.valid || tc.ready;
  assign step_en   = held_valid && out_free;
  assign msg.ready = !held_valid || out_free;

  tqfd_step u_step (
    .state      (st),
    .item       (held_item),
    .state_next (st_next),
    .emit       (emit),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      held_valid <= 1'b1;
    end else if (step_en) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      held_item <= msg.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_en) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tc.valid <= 1'b0;
    end else if (step_en && emit) begin
      tc.valid <= 1'b1;
    end else if (tc.ready) begin
      tc.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      tc.item <= res;
    end
  end

  // The lost count never leaves its saturated range.
  a_lost_range: assert property (@(posedge clk) disable iff (rst)
    st.lost_count != {1'b1, 10'd0})
    else $error("lost count outside its saturated range");

  // A restart leaves the synced-once flag clear.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step_en && held_item.cmd == CMD_RESTART |=> !st.synced_once)
    else $error("restart did not clear the sync flag");

  // A first-sync result marks the decoder as synced.
  a_first_sync: assert property (@(posedge clk) disable iff (rst)
    step_en && emit && res.first_sync |=> st.synced_once)
    else $error("first sync not recorded");

  // Every emitted result is presented on the next cycle.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    step_en && emit |=> tc.valid)
    else $error("emitted result not presented");

  // The decode stage never advances into a full result register.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    tc.valid && !tc.ready |-> !step_en)
    else $error("decode stage advanced over a stalled result");

endmodule
`default_nettype wire

/* bench/timecode_quarter_frame_decoder_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timecode_quarter_frame_decoder_core_test: self-checking bench for the decoder
// Drives quarter-frame, full-frame, restart and unused commands with random
// idling on both channels. Each accepted item is run through a local model of
// the decoder, and every delivered timecode is checked against the oldest
// expected one.
// ----------------------------------------------------------------------------
module timecode_quarter_frame_decoder_core_test;
  import tqfd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tqfd_in_if msg ();
  tqfd_out_if tc ();

  timecode_quarter_frame_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .msg(msg),
    .tc(tc)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [2:0] next_piece = '0;
  int         piece_gap = 0;
  bit         timecode_valid = 1'b0;
  bit         sync_seen = 1'b0;
  logic [4:0] frames_acc = '0;
  logic [5:0] seconds_acc = '0;
  logic [5:0] minutes_acc = '0;
  logic [4:0] hours_acc = '0;

  tqfd_result_t pending_timecodes[$];
  int mismatch_count = 0;
  int sent_items = 0;
  int idle_cycles = 0;
  int sink_hold_request = 0;
  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  function automatic logic [7:0] merge_nibble(input logic [7:0] acc, input logic [3:0] nib,
                                              input logic high);
    return high ? {nib, acc[3:0]} : {acc[7:4], nib};
  endfunction

  function automatic bit predict_timecode(input tqfd_item_t m, output tqfd_result_t r);
    logic [2:0] piece;
    logic [3:0] nib;
    logic [7:0] merged;
    logic [1:0] rate;
    bit         emit;
    piece = m.quarter_byte[6:4];
    nib = m.quarter_byte[3:0];
    rate = '0;
    emit = 1'b0;
    r = '0;
    case (m.cmd)
      CMD_QUARTER: begin
        if (piece != next_piece) begin
          piece_gap = piece_gap + int'(piece) - int'(next_piece);
          if (piece_gap > int'(LOST_MAX)) piece_gap = int'(LOST_MAX);
          if (piece_gap < int'(LOST_MIN)) piece_gap = int'(LOST_MIN);
        end
        next_piece = piece + 3'd1;
        case (piece[2:1])
          GROUP_FRAMES: begin
            merged = merge_nibble({3'b0, frames_acc}, nib, piece[0]);
            frames_acc = merged[4:0];
          end
          GROUP_SECONDS: begin
            merged = merge_nibble({2'b0, seconds_acc}, nib, piece[0]);
            seconds_acc = merged[5:0];
          end
          GROUP_MINUTES: begin
            merged = merge_nibble({2'b0, minutes_acc}, nib, piece[0]);
            minutes_acc = merged[5:0];
          end
          default: begin
            merged = merge_nibble({3'b0, hours_acc}, nib, piece[0]);
            rate = merged[6:5];
            hours_acc = merged[4:0];
          end
        endcase
        if (piece == PIECE_LAST) begin
          timecode_valid = (piece_gap == 0);
          next_piece = '0;
          piece_gap = 0;
          if (timecode_valid) begin
            r.hours = hours_acc;
            r.minutes = minutes_acc;
            r.seconds = seconds_acc;
            r.frames = frames_acc;
            r.rate_type = rate;
            r.from_full_frame = 1'b0;
            r.first_sync = !sync_seen;
            sync_seen = 1'b1;
            emit = 1'b1;
          end
        end
      end
      CMD_FULL: begin
        next_piece = '0;
        piece_gap = 0;
        timecode_valid = 1'b1;
        r.hours = m.full_hour_byte[4:0];
        r.minutes = m.full_minutes[5:0];
        r.seconds = m.full_seconds[5:0];
        r.frames = m.full_frames[4:0];
        r.rate_type = m.full_hour_byte[6:5];
        r.from_full_frame = 1'b1;
        r.first_sync = 1'b0;
        emit = 1'b1;
      end
      CMD_RESTART: begin
        next_piece = '0;
        piece_gap = 0;
        timecode_valid = 1'b0;
        sync_seen = 1'b0;
      end
      default: begin
      end
    endcase
    return emit;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : predict_accepted
    tqfd_result_t r;
    if (!rst && msg.valid && msg.ready) begin
      if (predict_timecode(msg.item, r)) pending_timecodes.push_back(r);
    end
  end

  always @(posedge clk) begin : check_delivered
    tqfd_result_t want;
    tqfd_result_t got;
    if (!rst && tc.valid && tc.ready) begin
      got = tc.item;
      if (pending_timecodes.size() == 0) begin
        note_mismatch("unexpected item, hours", -1, int'(got.hours));
      end else begin
        want = pending_timecodes.pop_front();
        if (want.hours != got.hours)
          note_mismatch("hours", int'(want.hours), int'(got.hours));
        if (want.minutes != got.minutes)
          note_mismatch("minutes", int'(want.minutes), int'(got.minutes));
        if (want.seconds != got.seconds)
          note_mismatch("seconds", int'(want.seconds), int'(got.seconds));
        if (want.frames != got.frames)
          note_mismatch("frames", int'(want.frames), int'(got.frames));
        if (want.rate_type != got.rate_type)
          note_mismatch("rate_type", int'(want.rate_type), int'(got.rate_type));
        if (want.from_full_frame != got.from_full_frame)
          note_mismatch("from_full_frame", int'(want.from_full_frame),
                        int'(got.from_full_frame));
        if (want.first_sync != got.first_sync)
          note_mismatch("first_sync", int'(want.first_sync), int'(got.first_sync));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg.valid && msg.ready) || (tc.valid && tc.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int hold;
    tc.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_request != 0) begin
        hold = sink_hold_request;
        sink_hold_request = 0;
        tc.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        tc.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        tc.ready <= 1'b1;
      end
    end
  end

  function automatic tqfd_item_t filler_item(input logic [1:0] cmd);
    tqfd_item_t m;
    m.cmd = cmd;
    m.quarter_byte = 7'($urandom_range(0, 127));
    m.full_hour_byte = 7'($urandom_range(0, 127));
    m.full_minutes = 7'($urandom_range(0, 127));
    m.full_seconds = 7'($urandom_range(0, 127));
    m.full_frames = 7'($urandom_range(0, 127));
    return m;
  endfunction

  function automatic tqfd_item_t quarter_item(input logic [2:0] piece, input logic [3:0] nib);
    tqfd_item_t m;
    m = filler_item(CMD_QUARTER);
    m.quarter_byte = {piece, nib};
    return m;
  endfunction

  task automatic send_msg(input tqfd_item_t m);
    int gap;
    if (source_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      msg.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    msg.valid <= 1'b1;
    msg.item <= m;
    @(posedge clk);
    while (!msg.ready) @(posedge clk);
    if (m.cmd != CMD_UNUSED) sent_items++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    msg.valid <= 1'b0;
    while (pending_timecodes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_timecode(input bit allow_fault);
    int         fault_at;
    int         fault_kind;
    logic [2:0] piece;
    logic [3:0] nib;
    fault_at = (allow_fault && $urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : -1;
    fault_kind = $urandom_range(0, 3);
    for (int p = 0; p < 8; p++) begin
      nib = 4'($urandom_range(0, 15));
      if (p == fault_at) begin
        case (fault_kind)
          0: continue;
          1: begin
            piece = 3'($urandom_range(0, 7));
            send_msg(quarter_item(piece, nib));
            continue;
          end
          2: begin
            case ($urandom_range(0, 2))
              0: send_msg(filler_item(CMD_FULL));
              1: send_msg(filler_item(CMD_RESTART));
              default: send_msg(filler_item(CMD_UNUSED));
            endcase
          end
          default: send_msg(quarter_item(3'(p), 4'($urandom_range(0, 15))));
        endcase
      end
      send_msg(quarter_item(3'(p), nib));
    end
  endtask

  task automatic test_full_frame();
    tqfd_item_t m;
    m = '0;
    m.cmd = CMD_FULL;
    send_msg(m);
    m.full_hour_byte = 7'h7f;
    m.full_minutes = 7'h7f;
    m.full_seconds = 7'h7f;
    m.full_frames = 7'h7f;
    m.quarter_byte = 7'h7f;
    send_msg(m);
  endtask

  task automatic test_quarter_sequence();
    for (int p = 0; p < 8; p++) send_msg(quarter_item(3'(p), 4'hf));
  endtask

  task automatic test_piece_gap();
    logic [2:0] order [8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
    send_msg(quarter_item(PIECE_LAST, 4'h5));
    // The swapped pieces and the piece after them cancel, so this timecode is valid.
    for (int i = 0; i < 8; i++) send_msg(quarter_item(order[i], 4'h0));
  endtask

  task automatic test_restart_and_unused();
    send_msg(filler_item(CMD_RESTART));
    for (int p = 0; p < 8; p++) begin
      if (p == 4) send_msg(filler_item(CMD_UNUSED));
      send_msg(quarter_item(3'(p), 4'($urandom_range(0, 15))));
    end
  endtask

  task automatic test_result_stall();
    source_gaps = 1'b0;
    sink_hold_request = 64;
    for (int i = 0; i < 24; i++) send_msg(filler_item(CMD_FULL));
    wait_for_drain();
    source_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(input int item_goal);
    int goal;
    int pick;
    goal = sent_items + item_goal;
    while (sent_items < goal) begin
      pick = $urandom_range(0, 15);
      if (pick < 10) send_random_timecode(1'b1);
      else if (pick < 12) send_msg(filler_item(CMD_FULL));
      else if (pick == 12) send_msg(filler_item(CMD_RESTART));
      else if (pick == 13) send_msg(filler_item(CMD_UNUSED));
      else send_msg(filler_item(CMD_QUARTER));
    end
  endtask

  task automatic test_lost_limit();
    // A repeated piece drives the lost count down by one each time; the run goes
    // past the point where the count reaches its negative limit.
    send_msg(quarter_item(PIECE_LAST - 3'd1, 4'($urandom_range(0, 15))));
    for (int i = 0; i < 1040; i++)
      send_msg(quarter_item(PIECE_LAST - 3'd1, 4'($urandom_range(0, 15))));
    send_msg(quarter_item(PIECE_LAST, 4'($urandom_range(0, 15))));
    send_random_timecode(1'b0);
  endtask

  initial begin
    msg.valid = 1'b0;
    msg.item = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_full_frame();
    test_quarter_sequence();
    test_piece_gap();
    test_restart_and_unused();
    test_result_stall();
    test_random_traffic(30);
    test_lost_limit();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(30);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
